// ===== hw/rtl/bprf_pkg.sv =====
`default_nettype none

package bprf_pkg;

   localparam int RAW_ENTRIES     = 1024;
   localparam int RAW_AW          = $clog2(RAW_ENTRIES);
   localparam int DISPLAY_ENTRIES = 1280;
   localparam int DISPLAY_AW      = 11;

   localparam logic [7:0] RED_KEEP_BITS  = 8'hEF;
   localparam logic [7:0] LEGACY_RED_BIT = 8'h10;
   localparam logic [RAW_AW-1:0] ROM_LOW_SRC_BASE = 10'h300;

   localparam logic [1:0] CH_RED   = 2'd0;
   localparam logic [1:0] CH_GREEN = 2'd1;
   localparam logic [1:0] CH_BLUE  = 2'd2;

   typedef enum logic [1:0] {
      CMD_READ         = 2'd0,
      CMD_WRITE        = 2'd1,
      CMD_WRITE_LEGACY = 2'd2,
      CMD_LOOKUP       = 2'd3
   } cmd_type;

   typedef struct packed {
      logic              valid;
      cmd_type           cmd;
      logic [1:0]        channel;
      logic              lookup_hit;
   } ctrl_type;

   typedef struct packed {
      logic [2:0]        en;
      logic [RAW_AW-1:0] addr;
      logic [7:0]        data;
   } wr_req_type;

   function automatic logic [7:0] nib_swap(input logic [7:0] v);
      nib_swap = {v[3:0], v[7:4]};
   endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/banked_palette_register_file.sv =====
// Banked palette register file.
// Requests enter on the req_ ports and are taken at a rising edge with start
// high and busy low. Every request, writes included, gives one response: the
// rsp_ ports carry it for exactly one cycle with rsp_valid high, once it has
// passed the control and format registers. Unproduced fields are 0.
// A new request may be taken in every cycle, so throughput is one request per
// clock; a read sees every write taken in an earlier cycle.
// The csr_ port writes the access bank, which selects the 256-entry bank that
// reads and writes address. Write it only while no request is in flight.
// Display lookups cover 1280 entries; the top bank mirrors the ROM palette.
// After reset, busy stays high while a sweep clears the three 1024-entry
// channel memories, one entry per cycle; no request is taken then,
// although the csr_ port still works. The receiver cannot stall: a response
// is valid for its single cycle only.
`default_nettype none

module banked_palette_register_file (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            start,
   output logic                                 busy,
   input  wire logic [1:0]                      req_cmd,
   input  wire logic [1:0]                      req_channel,
   input  wire logic [7:0]                      req_reg_index,
   input  wire logic [7:0]                      req_write_data,
   input  wire logic [bprf_pkg::DISPLAY_AW-1:0] req_display_index,
   output logic                                 rsp_valid,
   output logic [7:0]                           rsp_read_data,
   output logic [7:0]                           rsp_disp_red,
   output logic [7:0]                           rsp_disp_green,
   output logic [7:0]                           rsp_disp_blue,
   input  wire logic                            csr_write_enable,
   input  wire logic [1:0]                      csr_write_data
);

   logic [1:0]                    bank_ff;
   logic                          clearing;
   logic                          accept;
   bprf_pkg::wr_req_type          wr_req;
   logic [bprf_pkg::RAW_AW-1:0]   rd_addr;
   bprf_pkg::ctrl_type            ctrl;
   bprf_pkg::ctrl_type            ctrl_ff;
   logic [7:0]                    rd_red;
   logic [7:0]                    rd_green;
   logic [7:0]                    rd_blue;

   assign accept = start && !clearing;
   assign busy   = clearing;

   always_ff @(posedge clock) begin
      if (reset) begin
         bank_ff <= 2'd0;
      end else begin
         if (csr_write_enable) begin
            bank_ff <= csr_write_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_ff.valid <= 1'b0;
      end else begin
         ctrl_ff.valid <= ctrl.valid;
      end
      ctrl_ff.cmd        <= ctrl.cmd;
      ctrl_ff.channel    <= ctrl.channel;
      ctrl_ff.lookup_hit <= ctrl.lookup_hit;
   end

   bprf_decode u_decode (
      .access_bank   (bank_ff),
      .accept        (accept),
      .cmd           (req_cmd),
      .channel       (req_channel),
      .reg_index     (req_reg_index),
      .write_data    (req_write_data),
      .display_index (req_display_index),
      .wr_req        (wr_req),
      .rd_addr       (rd_addr),
      .ctrl          (ctrl)
   );

   bprf_store u_store (
      .clock    (clock),
      .reset    (reset),
      .wr_req   (wr_req),
      .rd_addr  (rd_addr),
      .rd_red   (rd_red),
      .rd_green (rd_green),
      .rd_blue  (rd_blue),
      .clearing (clearing)
   );

   bprf_format u_format (
      .clock          (clock),
      .reset          (reset),
      .ctrl           (ctrl_ff),
      .rd_red         (rd_red),
      .rd_green       (rd_green),
      .rd_blue        (rd_blue),
      .rsp_valid      (rsp_valid),
      .rsp_read_data  (rsp_read_data),
      .rsp_disp_red   (rsp_disp_red),
      .rsp_disp_green (rsp_disp_green),
      .rsp_disp_blue  (rsp_disp_blue)
   );

endmodule

`default_nettype wire

// ===== hw/rtl/bprf_decode.sv =====
`default_nettype none

module bprf_decode (
   input  wire logic [1:0]                     access_bank,
   input  wire logic                           accept,
   input  wire logic [1:0]                     cmd,
   input  wire logic [1:0]                     channel,
   input  wire logic [7:0]                     reg_index,
   input  wire logic [7:0]                     write_data,
   input  wire logic [bprf_pkg::DISPLAY_AW-1:0] display_index,
   output bprf_pkg::wr_req_type                wr_req,
   output logic [bprf_pkg::RAW_AW-1:0]         rd_addr,
   output bprf_pkg::ctrl_type                  ctrl
);

   bprf_pkg::cmd_type             cmd_e;
   logic [bprf_pkg::RAW_AW-1:0]   entry;
   logic [bprf_pkg::RAW_AW-1:0]   rom_src;
   logic [7:0]                    legacy_byte;
   logic                          is_write;

   assign cmd_e = bprf_pkg::cmd_type'(cmd);
   assign entry = {access_bank, reg_index};

   // The ROM bank is never written directly; each entry always equals the
   // display value of the entry it mirrors, so lookups read that source.
   always_comb begin
      if (display_index[7:4] == 4'd0) begin
         rom_src = bprf_pkg::ROM_LOW_SRC_BASE + {6'd0, display_index[3:0]};
      end else begin
         rom_src = {2'b00, display_index[7:0]};
      end
   end

   always_comb begin
      legacy_byte = {write_data[3:0], write_data[3:0]};
      if (channel == bprf_pkg::CH_RED) begin
         legacy_byte = (legacy_byte & bprf_pkg::RED_KEEP_BITS)
                     | (write_data & bprf_pkg::LEGACY_RED_BIT);
      end
   end

   always_comb begin
      is_write = 1'b0;
      rd_addr  = entry;
      unique case (cmd_e)
         bprf_pkg::CMD_READ: begin
            rd_addr = entry;
         end
         bprf_pkg::CMD_WRITE, bprf_pkg::CMD_WRITE_LEGACY: begin
            is_write = 1'b1;
         end
         bprf_pkg::CMD_LOOKUP: begin
            if (display_index[10]) begin
               rd_addr = rom_src;
            end else begin
               rd_addr = display_index[bprf_pkg::RAW_AW-1:0];
            end
         end
         default: begin
            is_write = 1'b0;
         end
      endcase
   end

   always_comb begin
      wr_req.addr = entry;
      wr_req.data = (cmd_e == bprf_pkg::CMD_WRITE) ? write_data : legacy_byte;
      wr_req.en   = 3'b000;
      if (accept && is_write) begin
         wr_req.en[0] = (channel == bprf_pkg::CH_RED);
         wr_req.en[1] = (channel == bprf_pkg::CH_GREEN);
         wr_req.en[2] = (channel == bprf_pkg::CH_BLUE);
      end
   end

   assign ctrl.valid      = accept;
   assign ctrl.cmd        = cmd_e;
   assign ctrl.channel    = channel;
   assign ctrl.lookup_hit =
      (display_index < bprf_pkg::DISPLAY_AW'(bprf_pkg::DISPLAY_ENTRIES));

endmodule

`default_nettype wire

// ===== hw/rtl/bprf_store.sv =====
`default_nettype none

module bprf_store (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire bprf_pkg::wr_req_type         wr_req,
   input  wire logic [bprf_pkg::RAW_AW-1:0]  rd_addr,
   output logic [7:0]                        rd_red,
   output logic [7:0]                        rd_green,
   output logic [7:0]                        rd_blue,
   output logic                              clearing
);

   logic [7:0] red_mem   [bprf_pkg::RAW_ENTRIES];
   logic [7:0] green_mem [bprf_pkg::RAW_ENTRIES];
   logic [7:0] blue_mem  [bprf_pkg::RAW_ENTRIES];

   logic                        clearing_ff;
   logic [bprf_pkg::RAW_AW-1:0] clr_cnt_ff;
   logic [bprf_pkg::RAW_AW-1:0] clr_cnt_in;
   logic                        clearing_in;

   logic [2:0]                  we;
   logic [bprf_pkg::RAW_AW-1:0] waddr;
   logic [7:0]                  wdata;
   logic [7:0]                  rd_red_ff;
   logic [7:0]                  rd_green_ff;
   logic [7:0]                  rd_blue_ff;

   always_comb begin
      clr_cnt_in  = clr_cnt_ff + bprf_pkg::RAW_AW'(1);
      clearing_in = clearing_ff && (clr_cnt_ff != {bprf_pkg::RAW_AW{1'b1}});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff <= 1'b1;
         clr_cnt_ff  <= '0;
      end else if (clearing_ff) begin
         clearing_ff <= clearing_in;
         clr_cnt_ff  <= clr_cnt_in;
      end
   end

   assign we    = clearing_ff ? 3'b111 : wr_req.en;
   assign waddr = clearing_ff ? clr_cnt_ff : wr_req.addr;
   assign wdata = clearing_ff ? 8'd0 : wr_req.data;

   always_ff @(posedge clock) begin
      if (we[0]) begin
         red_mem[waddr] <= wdata;
      end
      rd_red_ff <= red_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (we[1]) begin
         green_mem[waddr] <= wdata;
      end
      rd_green_ff <= green_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (we[2]) begin
         blue_mem[waddr] <= wdata;
      end
      rd_blue_ff <= blue_mem[rd_addr];
   end

   assign rd_red   = rd_red_ff;
   assign rd_green = rd_green_ff;
   assign rd_blue  = rd_blue_ff;
   assign clearing = clearing_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/bprf_format.sv =====
`default_nettype none

module bprf_format (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire bprf_pkg::ctrl_type  ctrl,
   input  wire logic [7:0]          rd_red,
   input  wire logic [7:0]          rd_green,
   input  wire logic [7:0]          rd_blue,
   output logic                     rsp_valid,
   output logic [7:0]               rsp_read_data,
   output logic [7:0]               rsp_disp_red,
   output logic [7:0]               rsp_disp_green,
   output logic [7:0]               rsp_disp_blue
);

   logic       valid_ff;
   logic [7:0] read_data_ff, read_data_in;
   logic [7:0] disp_red_ff, disp_red_in;
   logic [7:0] disp_green_ff, disp_green_in;
   logic [7:0] disp_blue_ff, disp_blue_in;

   always_comb begin
      read_data_in  = 8'd0;
      disp_red_in   = 8'd0;
      disp_green_in = 8'd0;
      disp_blue_in  = 8'd0;
      if (ctrl.valid && ctrl.cmd == bprf_pkg::CMD_READ) begin
         case (ctrl.channel)
            bprf_pkg::CH_RED:   read_data_in = rd_red;
            bprf_pkg::CH_GREEN: read_data_in = rd_green;
            bprf_pkg::CH_BLUE:  read_data_in = rd_blue;
            default:            read_data_in = 8'd0;
         endcase
      end
      if (ctrl.valid && ctrl.cmd == bprf_pkg::CMD_LOOKUP && ctrl.lookup_hit) begin
         disp_red_in   = bprf_pkg::nib_swap(rd_red & bprf_pkg::RED_KEEP_BITS);
         disp_green_in = bprf_pkg::nib_swap(rd_green);
         disp_blue_in  = bprf_pkg::nib_swap(rd_blue);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= ctrl.valid;
      end
      read_data_ff  <= read_data_in;
      disp_red_ff   <= disp_red_in;
      disp_green_ff <= disp_green_in;
      disp_blue_ff  <= disp_blue_in;
   end

   assign rsp_valid      = valid_ff;
   assign rsp_read_data  = read_data_ff;
   assign rsp_disp_red   = disp_red_ff;
   assign rsp_disp_green = disp_green_ff;
   assign rsp_disp_blue  = disp_blue_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/bprf_checker.sv =====
`default_nettype none

module bprf_checker (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic        busy,
   input  wire logic [1:0]  req_cmd,
   input  wire logic [10:0] req_display_index,
   input  wire logic        rsp_valid,
   input  wire logic [7:0]  rsp_read_data,
   input  wire logic [7:0]  rsp_disp_red,
   input  wire logic [7:0]  rsp_disp_green,
   input  wire logic [7:0]  rsp_disp_blue
);

   // Every response follows a request that was taken.
   a_rsp_has_request: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, 2))
      else $error("response without a request two cycles earlier");

   // Every request taken gives a response.
   a_request_gets_rsp: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> ##1 rsp_valid)
      else $error("request lost");

   // Only a read command returns read data.
   a_read_data_only_on_read: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && $past(req_cmd, 2) != bprf_pkg::CMD_READ) |-> rsp_read_data == 8'd0)
      else $error("read data on a non-read response");

   // A lookup past the last display entry returns zero colors.
   a_lookup_out_of_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && $past(req_display_index, 2) >= 11'd1280) |->
         (rsp_disp_red == 8'd0 && rsp_disp_green == 8'd0 && rsp_disp_blue == 8'd0))
      else $error("out-of-range lookup returned color data");

   // The clearing sweep holds off requests right after reset.
   a_busy_after_reset: assert property (@(posedge clock)
      $fell(reset) |-> busy)
      else $error("block not busy right after reset");

endmodule

bind banked_palette_register_file bprf_checker u_bprf_checker (
   .clock             (clock),
   .reset             (reset),
   .start             (start),
   .busy              (busy),
   .req_cmd           (req_cmd),
   .req_display_index (req_display_index),
   .rsp_valid         (rsp_valid),
   .rsp_read_data     (rsp_read_data),
   .rsp_disp_red      (rsp_disp_red),
   .rsp_disp_green    (rsp_disp_green),
   .rsp_disp_blue     (rsp_disp_blue)
);

`default_nettype wire
